[design/srd_pkg.sv]
package srd_pkg;

   localparam int MAX_REACH   = 64;
   localparam int REACH_RESET = 25;
   localparam int CFG_W       = 7;
   localparam int TDATA_W     = 8;

   localparam int RCH_W       = $clog2(MAX_REACH + 1);
   localparam int SW          = $clog2(2 * MAX_REACH);
   localparam int SINCE_NONE  = 2 * MAX_REACH - 1;

   localparam int QUEUE_DEPTH = MAX_REACH + 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic black;
      logic row_end;
   } cell_item_type;

   typedef struct packed {
      logic             pop;
      logic [CNT_W-1:0] base;
      logic [CNT_W-1:0] push_cnt;
      logic             row_last;
      logic [SW-1:0]    since;
      logic [SW-1:0]    thresh;
   } cell_ctl_type;

endpackage

[design/srd_cell.sv]
module srd_cell (
   input  logic                      clock,
   input  logic [srd_pkg::CNT_W-1:0] cell_index,
   input  srd_pkg::cell_ctl_type     ctl,
   input  srd_pkg::cell_item_type    neighbor,
   output srd_pkg::cell_item_type    item
);

   srd_pkg::cell_item_type    item_ff;
   srd_pkg::cell_item_type    item_in;
   logic [srd_pkg::CNT_W-1:0] offset;
   logic                      load;
   logic [srd_pkg::SW:0]      reach_pos;

   always_comb begin
      offset    = cell_index - ctl.base;
      load      = (cell_index >= ctl.base) && (offset < ctl.push_cnt);
      reach_pos = {1'b0, ctl.since} + (srd_pkg::SW + 1)'(offset);
      item_in   = item_ff;
      if (load) begin
         item_in.black   = (reach_pos <= {1'b0, ctl.thresh});
         item_in.row_end = ctl.row_last &&
                           (offset == ctl.push_cnt - srd_pkg::CNT_W'(1));
      end else if (ctl.pop) begin
         item_in = neighbor;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item = item_ff;

endmodule

[design/binary_row_smear_dilation.sv]
// Horizontal run-length smear of a binary image streamed one pixel per transaction in
// row order, with tlast on the last pixel of each row. An output pixel is black when a
// black input pixel of the same row lies closer than the configured reach. Pixels are
// accepted at one per cycle; the output runs reach-1 pixels behind the input, and at
// row end the pending pixels of the row leave one per cycle while rsp_tready is high,
// from a shift queue of MAX_REACH+1 cells while the next row is already being accepted.
// Every row comes out with as many pixels as went in. req_tready drops only when the
// queue could not hold the flush of a row ending on the next pixel, which happens only
// when the result side stalls. A reach of 0 acts as 1 and a reach above MAX_REACH
// acts as MAX_REACH; change it between rows.
module binary_row_smear_dilation (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [srd_pkg::TDATA_W-1:0] req_tdata,   // [0] pixel_black, rest zero
   input  logic                        req_tlast,   // row_end
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [srd_pkg::TDATA_W-1:0] rsp_tdata,   // [0] out_black, rest zero
   output logic                        rsp_tlast,   // out_row_end
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [srd_pkg::CFG_W-1:0]   csr_data
);

   logic [srd_pkg::CFG_W-1:0] reach_ff;
   logic [srd_pkg::SW-1:0]    since_ff;
   logic [srd_pkg::SW-1:0]    since_in;
   logic [srd_pkg::RCH_W-1:0] fill_ff;
   logic [srd_pkg::RCH_W-1:0] fill_in;
   logic [srd_pkg::CNT_W-1:0] count_ff;
   logic [srd_pkg::CNT_W-1:0] count_in;

   logic [srd_pkg::RCH_W-1:0] reach_c;
   logic [srd_pkg::RCH_W-1:0] delay;
   logic [srd_pkg::RCH_W-1:0] fill_next;
   logic [srd_pkg::RCH_W-1:0] first;
   logic [srd_pkg::RCH_W-1:0] top;
   logic [srd_pkg::SW-1:0]    since_new;
   logic [srd_pkg::CNT_W-1:0] push_cnt;
   logic                      req_accept;
   logic                      pop;

   srd_pkg::cell_ctl_type  ctl;
   srd_pkg::cell_item_type items [srd_pkg::QUEUE_DEPTH+1];

   always_comb begin
      if (reach_ff == '0) begin
         reach_c = srd_pkg::RCH_W'(1);
      end else if (32'(reach_ff) > srd_pkg::MAX_REACH) begin
         reach_c = srd_pkg::RCH_W'(srd_pkg::MAX_REACH);
      end else begin
         reach_c = srd_pkg::RCH_W'(reach_ff);
      end
      delay = reach_c - srd_pkg::RCH_W'(1);

      if (32'(fill_ff) >= srd_pkg::MAX_REACH) begin
         fill_next = srd_pkg::RCH_W'(srd_pkg::MAX_REACH);
      end else begin
         fill_next = fill_ff + srd_pkg::RCH_W'(1);
      end
      first = (fill_next < reach_c) ? fill_next : reach_c;

      if (req_tdata[0]) begin
         since_new = '0;
      end else if (32'(since_ff) < srd_pkg::SINCE_NONE) begin
         since_new = since_ff + srd_pkg::SW'(1);
      end else begin
         since_new = since_ff;
      end

      req_tready = (srd_pkg::CNT_W'(srd_pkg::QUEUE_DEPTH) - count_ff) >=
                   srd_pkg::CNT_W'(first);
      req_accept = req_tvalid && req_tready;
      rsp_tvalid = (count_ff != '0);
      pop        = rsp_tvalid && rsp_tready;

      top      = req_tlast ? first : reach_c;
      push_cnt = '0;
      if (req_accept) begin
         if (req_tlast) begin
            push_cnt = srd_pkg::CNT_W'(first);
         end else if (fill_next > delay) begin
            push_cnt = srd_pkg::CNT_W'(1);
         end
      end

      ctl.pop      = pop;
      ctl.base     = count_ff - srd_pkg::CNT_W'(pop);
      ctl.push_cnt = push_cnt;
      ctl.row_last = req_tlast;
      ctl.since    = since_new;
      ctl.thresh   = srd_pkg::SW'(top) + srd_pkg::SW'(delay) - srd_pkg::SW'(1);

      count_in = count_ff - srd_pkg::CNT_W'(pop) + push_cnt;
      since_in = since_ff;
      fill_in  = fill_ff;
      if (req_accept) begin
         if (req_tlast) begin
            since_in = srd_pkg::SW'(srd_pkg::SINCE_NONE);
            fill_in  = '0;
         end else begin
            since_in = since_new;
            fill_in  = fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff <= srd_pkg::CFG_W'(srd_pkg::REACH_RESET);
         since_ff <= srd_pkg::SW'(srd_pkg::SINCE_NONE);
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (csr_valid) begin
            reach_ff <= csr_data;
         end
         since_ff <= since_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   assign csr_ready = 1'b1;
   assign items[srd_pkg::QUEUE_DEPTH] = '0;

   for (genvar g = 0; g < srd_pkg::QUEUE_DEPTH; g++) begin : g_cell
      srd_cell u_cell (
         .clock      (clock),
         .cell_index (srd_pkg::CNT_W'(g)),
         .ctl        (ctl),
         .neighbor   (items[g+1]),
         .item       (items[g])
      );
   end

   assign rsp_tdata = {(srd_pkg::TDATA_W - 1)'(0), items[0].black};
   assign rsp_tlast = items[0].row_end;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= srd_pkg::QUEUE_DEPTH)
      else $error("queue count exceeds its depth");

   a_row_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> fill_ff == '0 && count_ff != '0)
      else $error("row end did not restart the row or queue its flush");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> 32'(count_ff) + 32'(first) <= srd_pkg::QUEUE_DEPTH)
      else $error("transaction accepted without room for its results");

endmodule
